### design/pwcv_pkg.sv
// shared types and constants for the piecewise waveform command voltage unit
// request/response payload structs, csr register codes, sequencer states
// no dependencies
`default_nettype none

package pwcv_pkg;

   localparam int TIME_BITS         = 24;
   localparam int VOLT_BITS         = 16;
   localparam int SLOPE_BITS        = 32;
   localparam int FRAC_BITS         = 16;
   localparam int SPAN_BITS         = 16;
   localparam int STEPS_BITS        = 5;
   localparam int IDX_BITS          = 4;
   localparam int CSR_DATA_BITS     = 24;
   localparam int DEFAULT_MAX_STEPS = 16;

   // divider widths: voltage interpolation needs the full product,
   // the slope only the scaled voltage difference
   localparam int DIV_W       = VOLT_BITS + TIME_BITS;
   localparam int SLOPE_DIV_W = VOLT_BITS + FRAC_BITS;
   localparam int ITER_W      = $clog2(DIV_W + 1);

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [1:0] {
      CSR_BASE_VOLTAGE,
      CSR_TOTAL_DURATION,
      CSR_STEPS_IN_USE,
      CSR_SIM_STEP
   } csr_index_type;

   typedef struct packed {
      logic                        req_type;
      logic [IDX_BITS-1:0]         entry_index;
      logic [TIME_BITS-1:0]        entry_time;
      logic signed [VOLT_BITS-1:0] entry_voltage;
      logic                        entry_ramp;
      logic [TIME_BITS-1:0]        query_time;
   } req_item_type;

   typedef struct packed {
      logic signed [VOLT_BITS-1:0]  command_voltage;
      logic signed [SLOPE_BITS-1:0] segment_slope;
      logic [SPAN_BITS-1:0]         step_span;
      logic                         split_needed;
   } rsp_item_type;

   typedef struct packed {
      logic                        ramp;
      logic signed [VOLT_BITS-1:0] voltage;
      logic [TIME_BITS-1:0]        time_tick;
   } step_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_MUL,
      ST_VSTART,
      ST_VWAIT,
      ST_SSTART,
      ST_SWAIT,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic              start;
      logic [ITER_W-1:0] iters;
   } div_req_type;

endpackage

`default_nettype wire

### design/pwcv_div.sv
// restoring unsigned divider, one quotient bit per cycle
// dividend is aligned to the top; iters sets how many bits are produced
// depends on pwcv_pkg
`default_nettype none

module pwcv_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pwcv_pkg::div_req_type           div_req,
   input  wire logic [pwcv_pkg::DIV_W-1:0]      dividend,
   input  wire logic [pwcv_pkg::TIME_BITS-1:0]  divisor,
   output logic                                 done,
   output logic [pwcv_pkg::DIV_W-1:0]           quotient
);

   localparam int DW = pwcv_pkg::DIV_W;
   localparam int TW = pwcv_pkg::TIME_BITS;

   logic                         busy_ff;
   logic                         done_ff;
   logic [pwcv_pkg::ITER_W-1:0]  cnt_ff;
   logic [TW-1:0]                rem_ff;
   logic [TW-1:0]                den_ff;
   logic [DW-1:0]                quo_ff;

   logic [TW:0] shifted;
   logic [TW:0] diff;
   logic        fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == pwcv_pkg::ITER_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         cnt_ff <= div_req.iters;
         rem_ff <= '0;
         den_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         rem_ff <= fits ? diff[TW-1:0] : shifted[TW-1:0];
         quo_ff <= {quo_ff[DW-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### design/piecewise_waveform_command_voltage_unit.sv
// write request: accepted with no response; query request: answered from the csr values
// alone when the table is empty or the time is outside the waveform, else after a scan of
// the step entries (registered table read) and, for a ramp, a multiply and two bit-serial
// divider passes (voltage, then slope), each with its start state; one request at a time;
// reset clears the csr registers (sim_step to 1) and the sequencer; the step table is not
// cleared and holds whatever was last written
`default_nettype none

module piecewise_waveform_command_voltage_unit #(
   parameter int MAX_STEPS = pwcv_pkg::DEFAULT_MAX_STEPS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire pwcv_pkg::req_item_type              req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output pwcv_pkg::rsp_item_type                   rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire pwcv_pkg::csr_index_type             csr_index,
   input  wire logic [pwcv_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int TW     = pwcv_pkg::TIME_BITS;
   localparam int VW     = pwcv_pkg::VOLT_BITS;
   localparam int SW     = pwcv_pkg::SLOPE_BITS;
   localparam int DW     = pwcv_pkg::DIV_W;
   localparam int ADDR_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int CNT_W  = $clog2(MAX_STEPS + 1);

   // csr registers
   logic signed [VW-1:0]               base_voltage_ff;
   logic [TW-1:0]                      total_duration_ff;
   logic [pwcv_pkg::STEPS_BITS-1:0]    steps_in_use_ff;
   logic [pwcv_pkg::SPAN_BITS-1:0]     sim_step_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_voltage_ff   <= '0;
         total_duration_ff <= '0;
         steps_in_use_ff   <= '0;
         sim_step_ff       <= pwcv_pkg::SPAN_BITS'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            pwcv_pkg::CSR_BASE_VOLTAGE:   base_voltage_ff   <= csr_data[VW-1:0];
            pwcv_pkg::CSR_TOTAL_DURATION: total_duration_ff <= csr_data[TW-1:0];
            pwcv_pkg::CSR_STEPS_IN_USE:
               steps_in_use_ff <= csr_data[pwcv_pkg::STEPS_BITS-1:0];
            pwcv_pkg::CSR_SIM_STEP: sim_step_ff <= csr_data[pwcv_pkg::SPAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer and datapath registers
   pwcv_pkg::seq_state_type state_ff, state_in;
   logic [TW-1:0]           t_ff;
   logic [CNT_W-1:0]        k_ff;
   logic [CNT_W-1:0]        n_ff;
   logic [TW-1:0]           prev_t_ff;
   logic signed [VW-1:0]    prev_v_ff;
   logic [TW-1:0]           den_ff;
   logic [TW-1:0]           elapsed_ff;
   logic                    dv_neg_ff;
   logic [VW-1:0]           dv_mag_ff;
   logic [DW-1:0]           prod_ff;
   pwcv_pkg::rsp_item_type  res_ff;
   pwcv_pkg::rsp_item_type  rsp_ff;
   logic                    rsp_valid_ff;
   pwcv_pkg::step_type      rd_ff;

   pwcv_pkg::step_type      mem [MAX_STEPS];

   logic                    req_fire;
   logic                    query_fire;
   logic                    write_fire;
   logic                    write_in_range;
   logic [CNT_W-1:0]        n_in;
   logic                    query_empty;
   logic                    entry_passed;
   logic                    last_entry;
   logic [CNT_W-1:0]        k_next;
   logic signed [VW:0]      dv;
   logic [TW-1:0]           gap;
   logic                    load_out;
   pwcv_pkg::div_req_type   div_req;
   logic [DW-1:0]           div_dividend;
   logic                    div_done;
   logic [DW-1:0]           div_quo;
   logic [VW:0]             volt_delta;
   logic [VW:0]             volt_sum;
   logic [SW-1:0]           slope_val;

   always_comb begin
      req_fire       = req_valid && req_ready;
      query_fire     = req_fire && (req_data.req_type == pwcv_pkg::REQ_QUERY);
      write_fire     = req_fire && (req_data.req_type == pwcv_pkg::REQ_WRITE);
      write_in_range = int'(req_data.entry_index) < MAX_STEPS;
      if (int'(steps_in_use_ff) > MAX_STEPS) begin
         n_in = CNT_W'(MAX_STEPS);
      end else begin
         n_in = CNT_W'(steps_in_use_ff);
      end
      query_empty  = (n_in == '0) || (req_data.query_time >= total_duration_ff);
      entry_passed = rd_ff.time_tick <= t_ff;
      k_next       = k_ff + 1'b1;
      last_entry   = k_next == n_ff;
      dv           = {rd_ff.voltage[VW-1], rd_ff.voltage} - {prev_v_ff[VW-1], prev_v_ff};
      gap          = rd_ff.time_tick - t_ff;
   end

   // voltage and slope from the divider quotient, sign applied afterwards
   always_comb begin
      volt_delta = dv_neg_ff ? -{1'b0, div_quo[VW-1:0]} : {1'b0, div_quo[VW-1:0]};
      volt_sum   = {prev_v_ff[VW-1], prev_v_ff} + volt_delta;
      if (!dv_neg_ff) begin
         if (|div_quo[DW-1:SW-1]) begin
            slope_val = {1'b0, {(SW-1){1'b1}}};
         end else begin
            slope_val = div_quo[SW-1:0];
         end
      end else begin
         if ((|div_quo[DW-1:SW]) || (div_quo[SW-1] && (|div_quo[SW-2:0]))) begin
            slope_val = {1'b1, {(SW-1){1'b0}}};
         end else begin
            slope_val = -div_quo[SW-1:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pwcv_pkg::ST_IDLE: begin
            if (query_fire) begin
               state_in = query_empty ? pwcv_pkg::ST_DONE : pwcv_pkg::ST_READ;
            end
         end
         pwcv_pkg::ST_READ: state_in = pwcv_pkg::ST_CMP;
         pwcv_pkg::ST_CMP: begin
            if (entry_passed) begin
               state_in = last_entry ? pwcv_pkg::ST_DONE : pwcv_pkg::ST_READ;
            end else begin
               state_in = rd_ff.ramp ? pwcv_pkg::ST_MUL : pwcv_pkg::ST_DONE;
            end
         end
         pwcv_pkg::ST_MUL:    state_in = pwcv_pkg::ST_VSTART;
         pwcv_pkg::ST_VSTART: state_in = pwcv_pkg::ST_VWAIT;
         pwcv_pkg::ST_VWAIT: begin
            if (div_done) state_in = pwcv_pkg::ST_SSTART;
         end
         pwcv_pkg::ST_SSTART: state_in = pwcv_pkg::ST_SWAIT;
         pwcv_pkg::ST_SWAIT: begin
            if (div_done) state_in = pwcv_pkg::ST_DONE;
         end
         pwcv_pkg::ST_DONE: begin
            if (load_out) state_in = pwcv_pkg::ST_IDLE;
         end
         default: state_in = pwcv_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready     = state_ff == pwcv_pkg::ST_IDLE;
      load_out      = (state_ff == pwcv_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
      div_req.start = (state_ff == pwcv_pkg::ST_VSTART) || (state_ff == pwcv_pkg::ST_SSTART);
      if (state_ff == pwcv_pkg::ST_VSTART) begin
         div_req.iters = pwcv_pkg::ITER_W'(DW);
         div_dividend  = prod_ff;
      end else begin
         div_req.iters = pwcv_pkg::ITER_W'(pwcv_pkg::SLOPE_DIV_W);
         // scaled difference placed at the top, zero padding below
         div_dividend  = {dv_mag_ff, {(DW - VW){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwcv_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) rsp_ff <= res_ff;
   end

   // step table
   always_ff @(posedge clock) begin
      if (write_fire && write_in_range) begin
         mem[ADDR_W'(req_data.entry_index)] <= '{ramp:      req_data.entry_ramp,
                                                 voltage:   req_data.entry_voltage,
                                                 time_tick: req_data.entry_time};
      end
      rd_ff <= mem[k_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         pwcv_pkg::ST_IDLE: begin
            if (query_fire) begin
               t_ff                   <= req_data.query_time;
               k_ff                   <= '0;
               n_ff                   <= n_in;
               prev_t_ff              <= '0;
               prev_v_ff              <= base_voltage_ff;
               res_ff.command_voltage <= base_voltage_ff;
               res_ff.segment_slope   <= '0;
               res_ff.step_span       <= sim_step_ff;
               res_ff.split_needed    <= 1'b0;
            end
         end
         pwcv_pkg::ST_CMP: begin
            if (entry_passed) begin
               prev_t_ff <= rd_ff.time_tick;
               prev_v_ff <= rd_ff.voltage;
               k_ff      <= k_next;
               if (last_entry) res_ff.command_voltage <= rd_ff.voltage;
            end else begin
               den_ff     <= rd_ff.time_tick - prev_t_ff;
               elapsed_ff <= t_ff - prev_t_ff;
               dv_neg_ff  <= dv[VW];
               dv_mag_ff  <= dv[VW] ? VW'(-dv) : dv[VW-1:0];
               if (!rd_ff.ramp) res_ff.command_voltage <= prev_v_ff;
               // next step lands inside this sim step
               if (gap < TW'(sim_step_ff)) begin
                  res_ff.step_span    <= pwcv_pkg::SPAN_BITS'(gap);
                  res_ff.split_needed <= 1'b1;
               end
            end
         end
         pwcv_pkg::ST_MUL:
            prod_ff <= {{(DW - VW){1'b0}}, dv_mag_ff} * {{(DW - TW){1'b0}}, elapsed_ff};
         pwcv_pkg::ST_VWAIT: begin
            if (div_done) res_ff.command_voltage <= volt_sum[VW-1:0];
         end
         pwcv_pkg::ST_SWAIT: begin
            if (div_done) res_ff.segment_slope <= slope_val;
         end
         default: ;
      endcase
   end

   pwcv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .dividend (div_dividend),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### tb/tb_top.sv
// testbench for piecewise_waveform_command_voltage_unit: directed and random step-table
// loads and waveform queries, each result checked in order against an in-bench predictor
// depends on pwcv_pkg and the unit's top module
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIME_BITS     = pwcv_pkg::TIME_BITS;
   localparam int VOLT_BITS     = pwcv_pkg::VOLT_BITS;
   localparam int SLOPE_BITS    = pwcv_pkg::SLOPE_BITS;
   localparam int SPAN_BITS     = pwcv_pkg::SPAN_BITS;
   localparam int STEPS_BITS    = pwcv_pkg::STEPS_BITS;
   localparam int IDX_BITS      = pwcv_pkg::IDX_BITS;
   localparam int CSR_DATA_BITS = pwcv_pkg::CSR_DATA_BITS;

   localparam int MAX_STEPS     = pwcv_pkg::DEFAULT_MAX_STEPS;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 130;
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_ITEMS  = 1000;

   localparam logic [TIME_BITS-1:0]        TIME_MAX = '1;
   localparam logic signed [VOLT_BITS-1:0] VOLT_MIN = {1'b1, {(VOLT_BITS-1){1'b0}}};
   localparam logic signed [VOLT_BITS-1:0] VOLT_MAX = {1'b0, {(VOLT_BITS-1){1'b1}}};

   typedef enum int {RX_ALWAYS, RX_COIN, RX_BURSTY} rx_pattern_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   pwcv_pkg::req_item_type   req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   pwcv_pkg::rsp_item_type   rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   pwcv_pkg::csr_index_type  csr_index = pwcv_pkg::CSR_BASE_VOLTAGE;
   logic [CSR_DATA_BITS-1:0] csr_data  = '0;

   // shadow of the step table and the csr registers
   logic [TIME_BITS-1:0]        step_time_tab [MAX_STEPS];
   logic signed [VOLT_BITS-1:0] step_volt_tab [MAX_STEPS];
   logic                        step_ramp_tab [MAX_STEPS];
   logic signed [VOLT_BITS-1:0] cfg_base;
   logic [TIME_BITS-1:0]        cfg_duration;
   logic [STEPS_BITS-1:0]       cfg_steps;
   logic [SPAN_BITS-1:0]        cfg_sim_step;

   pwcv_pkg::rsp_item_type command_queue [$];

   int             fail_count       = 0;
   int             cycle_count      = 0;
   int             items_sent       = 0;
   int             burst_left       = 0;
   bit             rsp_hold_request = 1'b0;
   int             hold_left        = 0;
   int             stall_left       = 0;
   int             mode_left        = 0;
   rx_pattern_type rx_pattern       = RX_ALWAYS;

   piecewise_waveform_command_voltage_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // command voltage, slope, span and split flag at query time t
   function automatic pwcv_pkg::rsp_item_type waveform_at(logic [TIME_BITS-1:0] t);
      pwcv_pkg::rsp_item_type r;
      int           n;
      int           k;
      longint       now;
      longint       start_t;
      longint       end_t;
      longint       start_v;
      longint       dv;
      longint       den;
      longint       volt;
      longint       slope;
      longint       sim;
      now               = t;
      sim               = cfg_sim_step;
      r.command_voltage = cfg_base;
      r.segment_slope   = '0;
      r.step_span       = cfg_sim_step;
      r.split_needed    = 1'b0;
      n = (cfg_steps > MAX_STEPS) ? MAX_STEPS : int'(cfg_steps);
      if (n != 0 && t < cfg_duration) begin
         k = 0;
         while (k < n && step_time_tab[k] <= t) k++;
         if (k == n) begin
            r.command_voltage = step_volt_tab[n-1];
         end else begin
            if (k == 0) begin
               start_t = 0;
               start_v = cfg_base;
            end else begin
               start_t = step_time_tab[k-1];
               start_v = step_volt_tab[k-1];
            end
            end_t = step_time_tab[k];
            if (step_ramp_tab[k]) begin
               den   = end_t - start_t;
               dv    = longint'(step_volt_tab[k]) - start_v;
               volt  = start_v + (dv * (now - start_t)) / den;
               slope = (dv * 65536) / den;
               if (slope > 64'sd2147483647) slope = 64'sd2147483647;
               if (slope < -64'sd2147483648) slope = -64'sd2147483648;
               r.command_voltage = volt[VOLT_BITS-1:0];
               r.segment_slope   = slope[SLOPE_BITS-1:0];
            end else begin
               r.command_voltage = start_v[VOLT_BITS-1:0];
            end
            // next step lands inside this sim step
            if (end_t - now < sim) begin
               r.step_span    = SPAN_BITS'(end_t - now);
               r.split_needed = 1'b1;
            end
         end
      end
      return r;
   endfunction

   function automatic void compare_field(string field, logic signed [63:0] want,
                                         logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      pwcv_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (command_queue.size() == 0) begin
            $display("%0t: response with no query outstanding, expected none, actual %h",
                     $time, rsp_data);
            fail_count++;
         end else begin
            want = command_queue.pop_front();
            compare_field("command_voltage", want.command_voltage, rsp_data.command_voltage);
            compare_field("segment_slope", want.segment_slope, rsp_data.segment_slope);
            compare_field("step_span", want.step_span, rsp_data.step_span);
            compare_field("split_needed", want.split_needed, rsp_data.split_needed);
         end
      end
   end

   // response side: long hold on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (rsp_hold_request) begin
         rsp_hold_request = 1'b0;
         hold_left        = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left  = $urandom_range(20, 200);
            rx_pattern = rx_pattern_type'($urandom_range(0, 2));
         end else begin
            mode_left--;
         end
         case (rx_pattern)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            default: begin
               if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
               rsp_ready <= (stall_left == 0);
            end
         endcase
      end
   end

   function automatic pwcv_pkg::req_item_type random_item(logic kind);
      logic [95:0]            noise;
      pwcv_pkg::req_item_type item;
      noise         = {$urandom, $urandom, $urandom};
      item          = noise[$bits(pwcv_pkg::req_item_type)-1:0];
      item.req_type = kind;
      return item;
   endfunction

   function automatic logic signed [VOLT_BITS-1:0] random_voltage();
      case ($urandom_range(0, 5))
         0:       return VOLT_MIN;
         1:       return VOLT_MAX;
         2:       return '0;
         default: return VOLT_BITS'($urandom);
      endcase
   endfunction

   // half of them near step edges, where segments change
   function automatic logic [TIME_BITS-1:0] pick_query_time();
      logic [TIME_BITS-1:0] t;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: t = step_time_tab[$urandom_range(0, MAX_STEPS-1)]
                            + TIME_BITS'($urandom_range(0, 6)) - TIME_BITS'(3);
         5, 6, 7: t = (cfg_duration == 0) ? TIME_BITS'($urandom)
                                          : TIME_BITS'($urandom_range(0, cfg_duration));
         8:       t = TIME_BITS'($urandom);
         default: t = $urandom_range(0, 1) ? TIME_MAX : '0;
      endcase
      return t;
   endfunction

   // valid stays high after acceptance unless a gap drops it; callers resend or drop it
   task automatic send_request(pwcv_pkg::req_item_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.req_type == pwcv_pkg::REQ_WRITE) begin
         step_time_tab[item.entry_index] = item.entry_time;
         step_volt_tab[item.entry_index] = item.entry_voltage;
         step_ramp_tab[item.entry_index] = item.entry_ramp;
      end else begin
         command_queue.push_back(waveform_at(item.query_time));
      end
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_query(logic [TIME_BITS-1:0] t);
      pwcv_pkg::req_item_type item;
      item            = random_item(pwcv_pkg::REQ_QUERY);
      item.query_time = t;
      send_request(item);
   endtask

   task automatic send_step(int slot, logic [TIME_BITS-1:0] t,
                            logic signed [VOLT_BITS-1:0] v, logic ramp);
      pwcv_pkg::req_item_type item;
      item               = random_item(pwcv_pkg::REQ_WRITE);
      item.entry_index   = IDX_BITS'(slot);
      item.entry_time    = t;
      item.entry_voltage = v;
      item.entry_ramp    = ramp;
      send_request(item);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (command_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // unused upper data bits carry noise
   task automatic write_csr(pwcv_pkg::csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] word;
      word = CSR_DATA_BITS'($urandom);
      case (idx)
         pwcv_pkg::CSR_BASE_VOLTAGE:   word[VOLT_BITS-1:0]  = value[VOLT_BITS-1:0];
         pwcv_pkg::CSR_TOTAL_DURATION: word                 = value;
         pwcv_pkg::CSR_STEPS_IN_USE:   word[STEPS_BITS-1:0] = value[STEPS_BITS-1:0];
         default:                      word[SPAN_BITS-1:0]  = value[SPAN_BITS-1:0];
      endcase
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= word;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pwcv_pkg::CSR_BASE_VOLTAGE:   cfg_base     = word[VOLT_BITS-1:0];
         pwcv_pkg::CSR_TOTAL_DURATION: cfg_duration = word[TIME_BITS-1:0];
         pwcv_pkg::CSR_STEPS_IN_USE:   cfg_steps    = word[STEPS_BITS-1:0];
         default:                      cfg_sim_step = word[SPAN_BITS-1:0];
      endcase
   endtask

   task automatic apply_config(logic signed [VOLT_BITS-1:0] base,
                               logic [TIME_BITS-1:0] duration,
                               logic [STEPS_BITS-1:0] steps, logic [SPAN_BITS-1:0] sim);
      write_csr(pwcv_pkg::CSR_BASE_VOLTAGE, CSR_DATA_BITS'(base));
      write_csr(pwcv_pkg::CSR_TOTAL_DURATION, duration);
      write_csr(pwcv_pkg::CSR_STEPS_IN_USE, CSR_DATA_BITS'(steps));
      write_csr(pwcv_pkg::CSR_SIM_STEP, CSR_DATA_BITS'(sim));
      csr_valid <= 1'b0;
   endtask

   task automatic randomize_config();
      logic [TIME_BITS-1:0]  duration;
      logic [STEPS_BITS-1:0] steps;
      logic [SPAN_BITS-1:0]  sim;
      case ($urandom_range(0, 5))
         0, 1, 2: duration = TIME_MAX;
         3: duration = step_time_tab[$urandom_range(0, MAX_STEPS-1)]
                       + TIME_BITS'($urandom_range(0, 2));
         4:       duration = TIME_BITS'($urandom);
         default: duration = TIME_BITS'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 5))
         0:       steps = '0;
         1:       steps = STEPS_BITS'(MAX_STEPS);
         2:       steps = STEPS_BITS'($urandom_range(MAX_STEPS + 1, (1 << STEPS_BITS) - 1));
         default: steps = STEPS_BITS'($urandom_range(1, MAX_STEPS));
      endcase
      case ($urandom_range(0, 5))
         0:       sim = '0;
         1:       sim = SPAN_BITS'(1);
         2:       sim = '1;
         3:       sim = SPAN_BITS'($urandom_range(2, 300));
         default: sim = SPAN_BITS'($urandom);
      endcase
      apply_config(random_voltage(), duration, steps, sim);
   endtask

   // ascending step times, gaps from zero up to about a million ticks
   task automatic load_ascending_table();
      logic [TIME_BITS-1:0] t;
      t = '0;
      for (int i = 0; i < MAX_STEPS; i++) begin
         case ($urandom_range(0, 3))
            0:       t = t + TIME_BITS'($urandom_range(0, 3));
            1:       t = t + TIME_BITS'($urandom_range(1, 200));
            default: t = t + TIME_BITS'($urandom_range(1, 20'hF_FFFF));
         endcase
         send_step(i, t, random_voltage(), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_empty_table();
      send_query('0);
      send_query(TIME_MAX);
      wait_idle();
      apply_config(VOLT_MIN, TIME_MAX, '0, '1);
      send_query(TIME_BITS'($urandom));
   endtask

   task automatic test_table_load();
      send_step(0, 1, VOLT_MIN, 1'b1);
      send_step(1, 2, VOLT_MAX, 1'b1);
      send_step(2, 100, -5000, 1'b0);
      send_step(3, 1100, 0, 1'b1);
      for (int i = 4; i < MAX_STEPS; i++)
         send_step(i, TIME_BITS'(i) << 20, i[0] ? VOLT_MAX : VOLT_MIN, i[0]);
   endtask

   task automatic test_segments();
      wait_idle();
      // full-scale swings over one tick saturate the slope both ways
      apply_config(VOLT_MAX, TIME_MAX, STEPS_BITS'(MAX_STEPS), '1);
      send_query(0);
      send_query(1);
      send_query(50);
      send_query(600);
      send_query(TIME_MAX - 1);
      wait_idle();
      // more steps in use than the table holds
      apply_config(VOLT_MAX, TIME_MAX, '1, '1);
      send_query(24'h80_0000);
      wait_idle();
      // zero sim step
      apply_config(VOLT_MAX, TIME_MAX, STEPS_BITS'(MAX_STEPS), '0);
      send_query(600);
      wait_idle();
      // at and just before the end of the waveform
      apply_config(VOLT_MIN, 1000, STEPS_BITS'(MAX_STEPS), 300);
      send_query(999);
      send_query(1000);
      wait_idle();
      // past the last step in use, and a span equal to the sim step
      apply_config(-1, TIME_MAX, 3, 1);
      send_query(500);
      send_query(99);
   endtask

   task automatic test_response_backpressure();
      wait_idle();
      apply_config(random_voltage(), TIME_MAX, STEPS_BITS'(MAX_STEPS), 700);
      rsp_hold_request = 1'b1;
      repeat (12) send_query(pick_query_time());
      wait_idle();
      repeat (12) send_query(pick_query_time());
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int first;
      int phase_len;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         wait_idle();
         randomize_config();
         if ($urandom_range(0, 1)) load_ascending_table();
         phase_len = $urandom_range(10, 60);
         repeat (phase_len) begin
            // stray writes break the ascending order now and then
            if ($urandom_range(0, 9) == 0) send_request(random_item(pwcv_pkg::REQ_WRITE));
            else send_query(pick_query_time());
         end
      end
   endtask

   initial begin
      cfg_base     = '0;
      cfg_duration = '0;
      cfg_steps    = '0;
      cfg_sim_step = SPAN_BITS'(1);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_table_load();
      test_segments();
      test_response_backpressure();
      test_random_traffic();
      wait_idle();
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
